/* hw/rtl/pbp_pkg.sv */
`timescale 1ns / 1ps
// pbp_pkg: shared widths, register indexes and the classified word type
// for the pivot bucket partitioner; no dependencies
package pbp_pkg;

    localparam int DATA_W          = 32;
    localparam int BUCKET_W        = 3;
    localparam int NB_W            = 4;
    localparam int CFG_IDX_W       = 4;
    localparam int NUM_PIVOTS      = 7;
    localparam int DEF_CAPACITY    = 32;
    localparam int DEF_MAX_BUCKETS = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_FIRST  = CFG_IDX_W'(1);

    typedef logic signed [DATA_W-1:0] pbp_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [BUCKET_W-1:0]      bucket;
        logic                     final_item;
    } pbp_item_t;

endpackage

/* hw/rtl/pbp_front.sv */
`timescale 1ns / 1ps
// pbp_front: accepts input words, compares against the pivots and registers
// the classified word; depends on pbp_pkg
module pbp_front #(
    parameter int MAX_BUCKETS = pbp_pkg::DEF_MAX_BUCKETS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pbp_pkg::DATA_W-1:0]    s_sample_value,
    input  logic                                 s_final_item,
    input  pbp_pkg::pbp_word_t                   pivots [pbp_pkg::NUM_PIVOTS],
    input  logic [pbp_pkg::NB_W-1:0]             nb,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output pbp_pkg::pbp_item_t                   q_item
);
    import pbp_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    pbp_item_t           item_reg;
    logic [BUCKET_W-1:0] bucket;
    logic                run;
    logic                accept;

    // leading pivots passed, stopping at the first one failed
    always_comb begin
        bucket = '0;
        run    = 1'b1;
        for (int k = 1; k <= NUM_PIVOTS; k++) begin
            if (run && (k < MAX_BUCKETS) && (NB_W'(k) < nb)
                    && (s_sample_value >= pivots[k-1])) begin
                bucket = BUCKET_W'(k);
            end else begin
                run = 1'b0;
            end
        end
    end

    assign s_ready = !valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.value      <= s_sample_value;
            item_reg.bucket     <= bucket;
            item_reg.final_item <= s_final_item;
        end
    end

endmodule

/* hw/rtl/pbp_queue.sv */
`timescale 1ns / 1ps
// pbp_queue: short fifo of classified words between front and back
// depends on pbp_pkg
module pbp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pbp_pkg::pbp_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output pbp_pkg::pbp_item_t out_item
);
    import pbp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    pbp_item_t       entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg < CW'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hw/rtl/pbp_back.sv */
`timescale 1ns / 1ps
// pbp_back: appends classified words to the store and walks it bucket by
// bucket on a flush, with the output register; depends on pbp_pkg
module pbp_back #(
    parameter int CAPACITY    = pbp_pkg::DEF_CAPACITY,
    parameter int MAX_BUCKETS = pbp_pkg::DEF_MAX_BUCKETS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [pbp_pkg::NB_W-1:0]             nb,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  pbp_pkg::pbp_item_t                   q_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pbp_pkg::BUCKET_W-1:0]         m_bucket_number,
    output logic signed [pbp_pkg::DATA_W-1:0]    m_bucket_value,
    output logic                                 m_bucket_empty,
    output logic                                 m_bucket_end,
    output logic                                 m_overflow_seen,
    output logic                                 m_run_end
);
    import pbp_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BIX_W = $clog2(MAX_BUCKETS);

    localparam logic [1:0] S_FILL = 2'd0;
    localparam logic [1:0] S_BKT  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_CHK  = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        pbc_reg [MAX_BUCKETS];
    logic [CW-1:0]        pbc_next [MAX_BUCKETS];
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [BUCKET_W-1:0]  b_reg;
    logic [BUCKET_W-1:0]  b_next;
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        i_next;
    logic [CW-1:0]        seen_reg;
    logic [CW-1:0]        seen_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BUCKET_W-1:0]  out_bucket_reg;
    logic [BUCKET_W-1:0]  out_bucket_next;
    logic [DATA_W-1:0]    out_value_reg;
    logic [DATA_W-1:0]    out_value_next;
    logic                 out_empty_reg;
    logic                 out_empty_next;
    logic                 out_end_reg;
    logic                 out_end_next;
    logic                 out_ovf_reg;
    logic                 out_ovf_next;
    logic                 out_run_end_reg;
    logic                 out_run_end_next;

    logic [DATA_W-1:0]    value_store [CAPACITY];
    logic [BUCKET_W-1:0]  bucket_tag_store [CAPACITY];
    logic [DATA_W-1:0]    rd_value_reg;
    logic [BUCKET_W-1:0]  rd_tag_reg;

    logic                 pop;
    logic                 wr_en;
    logic                 load_out;
    logic                 out_free;
    logic                 last_b;
    logic                 word_end;
    logic [CW-1:0]        total;

    assign q_ready  = state_reg == S_FILL;
    assign pop      = q_valid && q_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign total    = pbc_reg[b_reg[BIX_W-1:0]];
    assign last_b   = (NB_W'(b_reg) + NB_W'(1)) == nb;
    assign word_end = (seen_reg + CW'(1)) == total;

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        pbc_next         = pbc_reg;
        ovf_next         = ovf_reg;
        b_next           = b_reg;
        i_next           = i_reg;
        seen_next        = seen_reg;
        wr_en            = 1'b0;
        load_out         = 1'b0;
        out_bucket_next  = b_reg;
        out_value_next   = '0;
        out_empty_next   = 1'b0;
        out_end_next     = 1'b0;
        out_ovf_next     = ovf_reg;
        out_run_end_next = 1'b0;

        unique case (state_reg)
            S_FILL: begin
                if (pop) begin
                    if (count_reg < CW'(CAPACITY)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        for (int k = 0; k < MAX_BUCKETS; k++) begin
                            if (q_item.bucket == BUCKET_W'(k)) begin
                                pbc_next[k] = pbc_reg[k] + CW'(1);
                            end
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (q_item.final_item) begin
                        state_next = S_BKT;
                        b_next     = '0;
                    end
                end
            end
            S_BKT: begin
                if (total == '0) begin
                    if (out_free) begin
                        load_out         = 1'b1;
                        out_empty_next   = 1'b1;
                        out_end_next     = 1'b1;
                        out_run_end_next = last_b;
                    end
                end else begin
                    i_next     = '0;
                    seen_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (rd_tag_reg == b_reg) begin
                    if (out_free) begin
                        load_out         = 1'b1;
                        out_value_next   = rd_value_reg;
                        out_end_next     = word_end;
                        out_run_end_next = word_end && last_b;
                        seen_next        = seen_reg + CW'(1);
                        if (!word_end) begin
                            i_next     = i_reg + CW'(1);
                            state_next = S_RD;
                        end
                    end
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            default: begin
                state_next = S_FILL;
            end
        endcase

        // bucket finished: next bucket or end of flush
        if (load_out && out_end_next) begin
            if (last_b) begin
                state_next = S_FILL;
                count_next = '0;
                ovf_next   = 1'b0;
                for (int k = 0; k < MAX_BUCKETS; k++) begin
                    pbc_next[k] = '0;
                end
            end else begin
                b_next     = b_reg + BUCKET_W'(1);
                state_next = S_BKT;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            b_reg         <= '0;
            i_reg         <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_BUCKETS; k++) begin
                pbc_reg[k] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            b_reg         <= b_next;
            i_reg         <= i_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            pbc_reg       <= pbc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_bucket_reg  <= out_bucket_next;
            out_value_reg   <= out_value_next;
            out_empty_reg   <= out_empty_next;
            out_end_reg     <= out_end_next;
            out_ovf_reg     <= out_ovf_next;
            out_run_end_reg <= out_run_end_next;
        end
    end

    // store with separate write and read addresses, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_store[count_reg[AW-1:0]]      <= q_item.value;
            bucket_tag_store[count_reg[AW-1:0]] <= q_item.bucket;
        end
        rd_value_reg <= value_store[i_reg[AW-1:0]];
        rd_tag_reg   <= bucket_tag_store[i_reg[AW-1:0]];
    end

    assign m_valid         = out_valid_reg;
    assign m_bucket_number = out_bucket_reg;
    assign m_bucket_value  = out_value_reg;
    assign m_bucket_empty  = out_empty_reg;
    assign m_bucket_end    = out_end_reg;
    assign m_overflow_seen = out_ovf_reg;
    assign m_run_end       = out_run_end_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("store count beyond capacity");

    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bucket_empty) |-> m_bucket_end)
        else $error("empty bucket word without bucket end");

    a_run_end_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_run_end) |-> m_bucket_end)
        else $error("run end without bucket end");

    a_no_pop_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_FILL) |-> !pop)
        else $error("queue popped during flush");
`endif

endmodule

/* hw/rtl/pivot_bucket_partitioner_core.sv */
`timescale 1ns / 1ps
// pivot_bucket_partitioner_core: top level with configuration registers,
// front classifier, queue and back store; depends on pbp_pkg and submodules
//
//   channel | ports                                   | direction
//   s_      | s_valid s_ready s_sample_value s_final_item | in
//   m_      | m_valid m_ready m_bucket_* m_overflow_seen m_run_end | out
//   cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// fill: one word a cycle while the input is not stalled, pivot compares done in parallel in the front
// flush: per bucket a bucket step (S_BKT), then a read (S_RD) and a check (S_CHK) per
// store entry scanned until all words of the bucket are sent; an empty bucket skips the scan
// input stalls during a flush; the queue lets the front run on while the back waits
// reset is synchronous, active low; the store needs no clearing
module pivot_bucket_partitioner_core #(
    parameter int CAPACITY    = pbp_pkg::DEF_CAPACITY,
    parameter int MAX_BUCKETS = pbp_pkg::DEF_MAX_BUCKETS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pbp_pkg::DATA_W-1:0]    s_sample_value,
    input  logic                                 s_final_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pbp_pkg::BUCKET_W-1:0]         m_bucket_number,
    output logic signed [pbp_pkg::DATA_W-1:0]    m_bucket_value,
    output logic                                 m_bucket_empty,
    output logic                                 m_bucket_end,
    output logic                                 m_overflow_seen,
    output logic                                 m_run_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pbp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pbp_pkg::DATA_W-1:0]           cfg_data
);
    import pbp_pkg::*;

    logic [NB_W-1:0] bucket_count_reg;
    pbp_word_t       pivot_reg [NUM_PIVOTS];
    logic [NB_W-1:0] nb;
    logic            cfg_wr;

    logic            fq_valid;
    logic            fq_ready;
    pbp_item_t       fq_item;
    logic            qb_valid;
    logic            qb_ready;
    pbp_item_t       qb_item;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= NB_W'(1);
            for (int k = 0; k < NUM_PIVOTS; k++) begin
                pivot_reg[k] <= '0;
            end
        end else if (cfg_wr) begin
            if (cfg_index == REG_BUCKET_COUNT) begin
                bucket_count_reg <= cfg_data[NB_W-1:0];
            end
            for (int k = 0; k < NUM_PIVOTS; k++) begin
                if (cfg_index == REG_PIVOT_FIRST + CFG_IDX_W'(k)) begin
                    pivot_reg[k] <= cfg_data;
                end
            end
        end
    end

    // zero means one bucket, large values saturate
    always_comb begin
        priority if (bucket_count_reg == '0) begin
            nb = NB_W'(1);
        end else if (bucket_count_reg > NB_W'(MAX_BUCKETS)) begin
            nb = NB_W'(MAX_BUCKETS);
        end else begin
            nb = bucket_count_reg;
        end
    end

    pbp_front #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_final_item   (s_final_item),
        .pivots         (pivot_reg),
        .nb             (nb),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_item         (fq_item)
    );

    pbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    pbp_back #(
        .CAPACITY    (CAPACITY),
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .nb              (nb),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_item          (qb_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bucket_number (m_bucket_number),
        .m_bucket_value  (m_bucket_value),
        .m_bucket_empty  (m_bucket_empty),
        .m_bucket_end    (m_bucket_end),
        .m_overflow_seen (m_overflow_seen),
        .m_run_end       (m_run_end)
    );

endmodule
